[design/barycentric_height_interpolation_core_macros.svh]
// assertion macros for the barycentric height core
`ifndef BARYCENTRIC_HEIGHT_INTERPOLATION_CORE_MACROS_SVH
`define BARYCENTRIC_HEIGHT_INTERPOLATION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BHI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("bhi check failed");
`define BHI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bhi reset check failed");
`else
`define BHI_ASSERT(lbl, prop)
`define BHI_ASSERT_RST(lbl, prop)
`endif
`endif

[design/bhi_pkg.sv]
`default_nettype none
package bhi_pkg;
  localparam int QBITS = 35;
  localparam int RW    = 103;
  localparam int DDW   = 68;

  typedef struct packed {
    logic                    valid;
    logic [RW-1:0]           rem;
    logic [DDW-1:0]          d;
    logic [QBITS-1:0]        q;
    logic                    neg;
    logic                    degen;
    logic signed [31:0]      ch;
  } div_t;
endpackage
`default_nettype wire

[design/barycentric_height_interpolation_core.sv]
// barycentric height interpolation over a triangle in the x-z plane
//
// input channel: in_valid / in_ready, one item holds three vertices (x, height, z)
// and a query point (x, z), all signed fixed point with the same format
// output channel: out_valid / out_ready, one result item per input item, in order:
// the interpolated height (rounded, saturated) and the degenerate flag
// a zero determinant gives degenerate = 1 and height = 0
//
// pipeline: 8 stages of differences, products and magnitudes, 35 restoring
// divider stages, one output register; throughput: one item per cycle while
// the receiver does not stall, set by the fully pipelined divider
//
// reset clears every stage valid bit; the pipeline is then empty
// when the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; an empty output register keeps the pipeline moving
`default_nettype none
module barycentric_height_interpolation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vertex_a_x,
  input  logic signed [31:0] vertex_a_height,
  input  logic signed [31:0] vertex_a_z,
  input  logic signed [31:0] vertex_b_x,
  input  logic signed [31:0] vertex_b_height,
  input  logic signed [31:0] vertex_b_z,
  input  logic signed [31:0] vertex_c_x,
  input  logic signed [31:0] vertex_c_height,
  input  logic signed [31:0] vertex_c_z,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] height,
  output logic               degenerate
);
  import bhi_pkg::*;
`include "barycentric_height_interpolation_core_macros.svh"

  logic en;
  div_t front_out, div_out;
  logic signed [35:0] sum;
  logic signed [31:0] h_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bhi_front u_front (
    .clk, .rst, .en, .in_valid,
    .vertex_a_x, .vertex_a_height, .vertex_a_z,
    .vertex_b_x, .vertex_b_height, .vertex_b_z,
    .vertex_c_x, .vertex_c_height, .vertex_c_z,
    .query_x, .query_z,
    .dout(front_out)
  );

  bhi_div u_div (
    .clk, .rst, .en,
    .din(front_out),
    .dout(div_out)
  );

  always_comb begin
    if (div_out.neg) begin
      sum = 36'(div_out.ch) - $signed({2'b00, div_out.q[QBITS-2:0]});
    end else begin
      sum = 36'(div_out.ch) + $signed({2'b00, div_out.q[QBITS-2:0]});
    end
    if (div_out.degen) begin
      h_next = '0;
    end else if (div_out.q[QBITS-1]) begin
      h_next = div_out.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (sum > 36'sh0_7fff_ffff) begin
      h_next = 32'sh7fff_ffff;
    end else if (sum < -36'sh0_8000_0000) begin
      h_next = 32'sh8000_0000;
    end else begin
      h_next = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_out.valid;
    end
    if (en) begin
      height     <= h_next;
      degenerate <= div_out.degen;
    end
  end

  `BHI_ASSERT_RST(a_reset_empty, rst |=> !out_valid)
  `BHI_ASSERT(a_degen_zero, out_valid && degenerate |-> height == 32'sd0)
  `BHI_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(height))
endmodule
`default_nettype wire

[design/bhi_front.sv]
`default_nettype none
module bhi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] vertex_a_x,
  input  logic signed [31:0] vertex_a_height,
  input  logic signed [31:0] vertex_a_z,
  input  logic signed [31:0] vertex_b_x,
  input  logic signed [31:0] vertex_b_height,
  input  logic signed [31:0] vertex_b_z,
  input  logic signed [31:0] vertex_c_x,
  input  logic signed [31:0] vertex_c_height,
  input  logic signed [31:0] vertex_c_z,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_z,
  output bhi_pkg::div_t      dout
);
  import bhi_pkg::*;

  // stage 1: differences
  logic v1;
  logic signed [32:0] dbzc, dcxb, daxc, dazc, dcza, dqx, dqz, dah, dbh;
  logic signed [31:0] ch1;
  // stage 2: products
  logic v2;
  logic signed [65:0] p1, p2, p3, p4, p5, p6;
  logic signed [32:0] dah2, dbh2;
  logic signed [31:0] ch2;
  // stage 3: determinant and weight numerators
  logic v3;
  logic signed [66:0] det3, n1, n2;
  logic signed [32:0] dah3, dbh3;
  logic signed [31:0] ch3;
  // stage 4: partial products
  logic v4;
  logic signed [66:0] det4;
  logic signed [67:0] m1lo, m2lo;
  logic signed [65:0] m1hi, m2hi;
  logic signed [31:0] ch4;
  // stage 5
  logic v5;
  logic signed [66:0] det5;
  logic signed [101:0] t1, t2;
  logic signed [31:0] ch5;
  // stage 6
  logic v6;
  logic signed [66:0] det6;
  logic signed [101:0] num6;
  logic signed [31:0] ch6;
  // stage 7: magnitudes
  logic v7, neg7, degen7;
  logic [101:0] nmag;
  logic [66:0]  dmag;
  logic signed [31:0] ch7;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v7;
    end
    if (en) begin
      dbzc <= $signed({vertex_b_z[31], vertex_b_z}) - $signed({vertex_c_z[31], vertex_c_z});
      dcxb <= $signed({vertex_c_x[31], vertex_c_x}) - $signed({vertex_b_x[31], vertex_b_x});
      daxc <= $signed({vertex_a_x[31], vertex_a_x}) - $signed({vertex_c_x[31], vertex_c_x});
      dazc <= $signed({vertex_a_z[31], vertex_a_z}) - $signed({vertex_c_z[31], vertex_c_z});
      dcza <= $signed({vertex_c_z[31], vertex_c_z}) - $signed({vertex_a_z[31], vertex_a_z});
      dqx  <= $signed({query_x[31], query_x}) - $signed({vertex_c_x[31], vertex_c_x});
      dqz  <= $signed({query_z[31], query_z}) - $signed({vertex_c_z[31], vertex_c_z});
      dah  <= $signed({vertex_a_height[31], vertex_a_height})
            - $signed({vertex_c_height[31], vertex_c_height});
      dbh  <= $signed({vertex_b_height[31], vertex_b_height})
            - $signed({vertex_c_height[31], vertex_c_height});
      ch1  <= vertex_c_height;

      p1 <= dbzc * daxc;
      p2 <= dcxb * dazc;
      p3 <= dbzc * dqx;
      p4 <= dcxb * dqz;
      p5 <= dcza * dqx;
      p6 <= daxc * dqz;
      dah2 <= dah;
      dbh2 <= dbh;
      ch2  <= ch1;

      det3 <= 67'(p1) + 67'(p2);
      n1   <= 67'(p3) + 67'(p4);
      n2   <= 67'(p5) + 67'(p6);
      dah3 <= dah2;
      dbh3 <= dbh2;
      ch3  <= ch2;

      det4 <= det3;
      m1lo <= $signed({1'b0, n1[33:0]}) * dah3;
      m1hi <= $signed(n1[66:34]) * dah3;
      m2lo <= $signed({1'b0, n2[33:0]}) * dbh3;
      m2hi <= $signed(n2[66:34]) * dbh3;
      ch4  <= ch3;

      det5 <= det4;
      t1   <= (102'(m1hi) <<< 34) + 102'(m1lo);
      t2   <= (102'(m2hi) <<< 34) + 102'(m2lo);
      ch5  <= ch4;

      det6 <= det5;
      num6 <= t1 + t2;
      ch6  <= ch5;

      neg7   <= num6[101] ^ det6[66];
      degen7 <= (det6 == '0);
      nmag   <= num6[101] ? 102'(-num6) : 102'(num6);
      dmag   <= det6[66] ? 67'(-det6) : 67'(det6);
      ch7    <= ch6;

      // round to nearest: (2|n| + |d|) / (2|d|)
      dout.rem   <= {nmag, 1'b0} + RW'(dmag);
      dout.d     <= {dmag, 1'b0};
      dout.q     <= '0;
      dout.neg   <= neg7;
      dout.degen <= degen7;
      dout.ch    <= ch7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end
endmodule
`default_nettype wire

[design/bhi_div.sv]
`default_nettype none
module bhi_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bhi_pkg::div_t din,
  output bhi_pkg::div_t dout
);
  import bhi_pkg::*;

  div_t st [0:QBITS];
  div_t nxt [0:QBITS-1];

  assign st[0] = din;
  assign dout  = st[QBITS];

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QBITS; i++) begin : g_step
    localparam int B = QBITS - 1 - i;
    logic [RW-1:0] cmp;
    assign cmp = RW'(st[i].d) << B;

    always_comb begin
      nxt[i] = st[i];
      if (st[i].rem >= cmp) begin
        nxt[i].rem  = st[i].rem - cmp;
        nxt[i].q[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else if (en) begin
        st[i+1].valid <= nxt[i].valid;
      end
      if (en) begin
        st[i+1].rem   <= nxt[i].rem;
        st[i+1].d     <= nxt[i].d;
        st[i+1].q     <= nxt[i].q;
        st[i+1].neg   <= nxt[i].neg;
        st[i+1].degen <= nxt[i].degen;
        st[i+1].ch    <= nxt[i].ch;
      end
    end
  end
endmodule
`default_nettype wire
